// ===== hw/rtl/tws_pkg.sv =====
// Shared types and constants for the three-wire serial master.
`timescale 1ns / 1ps

package tws_pkg;

  localparam int BITS_PER_BYTE = 8;
  localparam int PHASES_PER_BYTE = 2 * BITS_PER_BYTE;
  localparam int PHASE_CNT_W = $clog2(PHASES_PER_BYTE);
  localparam int BIT_IDX_W = $clog2(BITS_PER_BYTE);

  localparam int QUEUE_DEPTH_DEFAULT = 2;

  localparam int S_TDATA_W = 16;
  localparam int S_TUSER_W = 2;
  localparam int M_TDATA_W = 16;

  typedef enum logic [1:0] {
    ACT_START = 2'd0,
    ACT_SEND  = 2'd1,
    ACT_RECV  = 2'd2,
    ACT_STOP  = 2'd3
  } action_t;

  // One queued operation: what to do and the byte it works on.
  typedef struct packed {
    action_t                    kind;
    logic [BITS_PER_BYTE-1:0]   data;
  } cmd_t;

  // One pin phase as it leaves the block.
  typedef struct packed {
    logic                       last;
    logic [BITS_PER_BYTE-1:0]   rx_byte;
    logic                       data_drive;
    logic                       data_out;
    logic                       serial_clock;
    logic                       chip_select;
  } phase_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PRE_CLK,
    ST_PRE_CS,
    ST_BITS,
    ST_STOP_CLK,
    ST_STOP_CS
  } seq_state_t;

endpackage

// ===== hw/rtl/three_wire_serial_master_unit.sv =====
// Top level of the three-wire serial master.
`timescale 1ns / 1ps

// Three-wire serial master, LSB first. Each input item is one operation
// (s_tuser: 0 start and send command, 1 send byte, 2 receive byte, 3 stop) and
// produces one output item per pin phase, with tlast on the final phase of the
// operation. The back sequencer emits one phase per clock while the output is
// not stalled; a start gives 18 phases, a send or a receive 16, a stop 2. Queued
// operations follow one another with no idle cycle, and the front keeps
// accepting items while up to QUEUE_DEPTH operations wait behind the one in
// progress. Pin levels persist between items; a receive releases the data line
// and returns the byte on the last phase.
module three_wire_serial_master_unit #(
  parameter int QUEUE_DEPTH = tws_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // [7:0] tx_byte, [15:8] rx_bits
  input  logic [tws_pkg::S_TDATA_W-1:0] s_tdata,
  // [1:0] action
  input  logic [tws_pkg::S_TUSER_W-1:0] s_tuser,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // [0] chip_select, [1] serial_clock, [2] data_out, [3] data_drive,
  // [11:4] rx_byte, [15:12] zero
  output logic [tws_pkg::M_TDATA_W-1:0] m_tdata,
  output logic                          m_tlast
);
  import tws_pkg::*;

  cmd_t cmd;
  logic cmd_valid;
  logic cmd_pop;

  tws_front #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .cmd_valid (cmd_valid),
    .cmd_pop   (cmd_pop),
    .cmd       (cmd)
  );

  tws_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_pop   (cmd_pop),
    .cmd       (cmd),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

endmodule

// ===== hw/rtl/tws_queue.sv =====
// Small register queue between the front and the back.
`timescale 1ns / 1ps

module tws_queue #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [WIDTH-1:0] in_data,
  output logic             out_valid,
  input  logic             out_pop,
  output logic [WIDTH-1:0] out_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             push;
  logic             pop;

  assign in_ready  = (count != CW'(DEPTH));
  assign out_valid = (count != '0);
  assign out_data  = slots[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_pop && out_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

// ===== hw/rtl/tws_front.sv =====
// Front end: accepts input items, decodes them into operations and queues them.
`timescale 1ns / 1ps

module tws_front #(
  parameter int QUEUE_DEPTH = tws_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [tws_pkg::S_TDATA_W-1:0] s_tdata,
  input  logic [tws_pkg::S_TUSER_W-1:0] s_tuser,
  output logic                       cmd_valid,
  input  logic                       cmd_pop,
  output tws_pkg::cmd_t              cmd
);
  import tws_pkg::*;

  cmd_t                     cmd_in;
  logic [BITS_PER_BYTE-1:0] tx_byte;
  logic [BITS_PER_BYTE-1:0] rx_bits;
  logic [$bits(cmd_t)-1:0]  head;

  assign tx_byte = s_tdata[BITS_PER_BYTE-1:0];
  assign rx_bits = s_tdata[2*BITS_PER_BYTE-1:BITS_PER_BYTE];

  // A receive carries the sampled line levels, a stop zero; a start or a send the byte to send.
  always_comb begin
    cmd_in.kind = action_t'(s_tuser);
    unique case (action_t'(s_tuser))
      ACT_RECV: cmd_in.data = rx_bits;
      ACT_STOP: cmd_in.data = '0;
      default:  cmd_in.data = tx_byte;
    endcase
  end

  tws_queue #(
    .WIDTH ($bits(cmd_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_data   (cmd_in),
    .out_valid (cmd_valid),
    .out_pop   (cmd_pop),
    .out_data  (head)
  );

  assign cmd = cmd_t'(head);

endmodule

// ===== hw/rtl/tws_back.sv =====
// Back end: pin-phase sequencer with the pin state and the output register.
`timescale 1ns / 1ps

module tws_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cmd_valid,
  output logic                          cmd_pop,
  input  tws_pkg::cmd_t                 cmd,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [tws_pkg::M_TDATA_W-1:0] m_tdata,
  output logic                          m_tlast
);
  import tws_pkg::*;

  localparam logic [PHASE_CNT_W-1:0] LAST_PHASE = PHASE_CNT_W'(PHASES_PER_BYTE - 1);

  seq_state_t               state;
  seq_state_t               state_next;
  logic [PHASE_CNT_W-1:0]   cnt;
  action_t                  cur_kind;
  logic [BITS_PER_BYTE-1:0] cur_byte;

  logic cs_lvl;
  logic clk_lvl;
  logic data_lvl;
  logic drv;
  logic cs_next;
  logic clk_next;
  logic data_lvl_next;
  logic drv_next;

  phase_t phase;
  phase_t out_reg;

  logic                 advance;
  logic                 last_phase;
  logic [BIT_IDX_W-1:0] bit_idx;

  function automatic seq_state_t first_state(action_t kind);
    unique case (kind)
      ACT_START: return ST_PRE_CLK;
      ACT_STOP:  return ST_STOP_CLK;
      default:   return ST_BITS;
    endcase
  endfunction

  assign advance    = (state != ST_IDLE) && (!m_tvalid || m_tready);
  assign last_phase = (state == ST_STOP_CS) || ((state == ST_BITS) && (cnt == LAST_PHASE));
  // The next operation is taken as the current one emits its final phase.
  assign cmd_pop    = cmd_valid && ((state == ST_IDLE) || (advance && last_phase));
  assign bit_idx    = cnt[PHASE_CNT_W-1:1];

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (cmd_pop) state_next = first_state(cmd.kind);
      end
      ST_PRE_CLK: begin
        if (advance) state_next = ST_PRE_CS;
      end
      ST_PRE_CS: begin
        if (advance) state_next = ST_BITS;
      end
      ST_BITS: begin
        if (advance && last_phase) state_next = cmd_pop ? first_state(cmd.kind) : ST_IDLE;
      end
      ST_STOP_CLK: begin
        if (advance) state_next = ST_STOP_CS;
      end
      ST_STOP_CS: begin
        if (advance) state_next = cmd_pop ? first_state(cmd.kind) : ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cs_next       = cs_lvl;
    clk_next      = clk_lvl;
    data_lvl_next = data_lvl;
    drv_next      = drv;
    unique case (state)
      ST_PRE_CLK, ST_STOP_CLK: clk_next = 1'b1;
      ST_PRE_CS:  cs_next = 1'b1;
      ST_STOP_CS: cs_next = 1'b0;
      ST_BITS: begin
        clk_next = ~cnt[0];
        if (cur_kind == ACT_RECV) begin
          drv_next = 1'b0;
        end else begin
          drv_next      = 1'b1;
          data_lvl_next = cur_byte[bit_idx];
        end
      end
      default: ;
    endcase
    phase.chip_select  = cs_next;
    phase.serial_clock = clk_next;
    phase.data_out     = drv_next & data_lvl_next;
    phase.data_drive   = drv_next;
    phase.rx_byte      = (last_phase && (state == ST_BITS) && (cur_kind == ACT_RECV))
                         ? cur_byte : '0;
    phase.last         = last_phase;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      cnt      <= '0;
      cs_lvl   <= 1'b0;
      clk_lvl  <= 1'b0;
      data_lvl <= 1'b0;
      drv      <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd_pop) begin
        cnt <= '0;
      end else if (advance && (state == ST_BITS)) begin
        cnt <= cnt + PHASE_CNT_W'(1);
      end
      if (advance) begin
        cs_lvl   <= cs_next;
        clk_lvl  <= clk_next;
        data_lvl <= data_lvl_next;
        drv      <= drv_next;
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      cur_kind <= cmd.kind;
      cur_byte <= cmd.data;
    end
    if (advance) begin
      out_reg <= phase;
    end
  end

  assign m_tdata = M_TDATA_W'({out_reg.rx_byte, out_reg.data_drive, out_reg.data_out,
                               out_reg.serial_clock, out_reg.chip_select});
  assign m_tlast = out_reg.last;

  a_cs_up: assert property (@(posedge clk) disable iff (rst)
    (advance && (state == ST_PRE_CS)) |=> cs_lvl)
    else $error("chip select not raised after start");

  a_cs_down: assert property (@(posedge clk) disable iff (rst)
    (advance && (state == ST_STOP_CS)) |=> !cs_lvl)
    else $error("chip select not dropped after stop");

  a_clk_toggle: assert property (@(posedge clk) disable iff (rst)
    (advance && (state == ST_BITS) && (cnt != '0)) |=> (clk_lvl != $past(clk_lvl)))
    else $error("serial clock did not toggle within a byte");

  a_rx_on_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (out_reg.rx_byte != '0)) |-> out_reg.last)
    else $error("received byte shown before the final phase");

  a_release_quiet: assert property (@(posedge clk) disable iff (rst)
    (advance && (state == ST_BITS) && (cur_kind == ACT_RECV)) |=>
      (!drv && !out_reg.data_out))
    else $error("data line driven during receive");

endmodule
